>>> sv/timed_travel_position_estimator_core_defines.svh
// Assertion macros for the timed travel position estimator core
`ifndef TIMED_TRAVEL_POSITION_ESTIMATOR_CORE_DEFINES_SVH
`define TIMED_TRAVEL_POSITION_ESTIMATOR_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define TTPE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define TTPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/ttpe_pkg.sv
// Shared types and constants of the timed travel position estimator
`default_nettype none

package ttpe_pkg;

    localparam int TIME_W  = 48;
    localparam int MS_W    = 20;
    localparam int MS10_W  = 24;
    localparam int TOTAL_W = 31;
    localparam int POS_W   = 7;
    localparam int PCT_W   = 8;
    localparam int QUOT_W  = 7;
    localparam int STEP_W  = $clog2(QUOT_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [POS_W-1:0] FULL_PCT       = 7'd100;
    localparam logic [POS_W-1:0] INIT_POS_RESET = 7'd0;
    localparam logic [MS_W-1:0]  TRAVEL_RESET   = 20'd30000;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_POS   = 2'd2;

    typedef enum logic [2:0] {
        ACT_APP_MOVE    = 3'd0,
        ACT_APP_STOP    = 3'd1,
        ACT_REMOTE_UP   = 3'd2,
        ACT_REMOTE_DOWN = 3'd3,
        ACT_REMOTE_STOP = 3'd4,
        ACT_TICK        = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2,
        CMD_STOP = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [PCT_W-1:0]  target_percent;
        logic [TIME_W-1:0] now_us;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       radio_cmd;
        logic             report_valid;
        logic [POS_W-1:0] position;
        logic             moving;
    } out_item_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

>>> sv/ttpe_div.sv
// Restoring divider that yields the whole percent steps travelled, one bit a cycle
`default_nettype none

module ttpe_div
    import ttpe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [TOTAL_W-1:0] dividend,
    input  wire logic [MS10_W-1:0]  divisor,
    output div_stat_t               stat
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [MS10_W-1:0]   dvs_reg, dvs_next;
    logic [TOTAL_W:0]    shifted;
    logic [TOTAL_W:0]    diff;

    assign shifted = (TOTAL_W+1)'(dvs_reg) << step_reg;
    assign diff    = {1'b0, rem_reg} - shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(QUOT_W - 1);
            rem_next  = dividend;
            quot_next = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[TOTAL_W])
            begin
                rem_next            = diff[TOTAL_W-1:0];
                quot_next[step_reg] = 1'b1;
            end
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = quot_reg;

endmodule

`default_nettype wire

>>> sv/timed_travel_position_estimator_core.sv
// Top level of the timed travel position estimator: sequencer, state and result register.
// Sequence: an accepted item passes PREP, MUL and EVAL, then FINISH for a tick or ignored
// event; a stop or a move that ends in place passes APPLY first, a move that starts travel
// APPLY and SPAN, and syncing an in-flight move adds DIV for 7 quotient bits of division.
// A new item is taken only in IDLE, once the last one's result is registered.
// Reset: position and target 0, not moving, travel times 30000 ms, no result pending.
`default_nettype none
`include "timed_travel_position_estimator_core_defines.svh"

module timed_travel_position_estimator_core
    import ttpe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_PREP   = 8'b0000_0010,
        ST_MUL    = 8'b0000_0100,
        ST_EVAL   = 8'b0000_1000,
        ST_DIV    = 8'b0001_0000,
        ST_APPLY  = 8'b0010_0000,
        ST_SPAN   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    function automatic logic [MS10_W-1:0] times_ten(input logic [MS_W-1:0] ms);
        return (MS10_W'(ms) << 3) + (MS10_W'(ms) << 1);
    endfunction

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    state_t               state_reg, state_next;
    logic [MS_W-1:0]      lower_ms_reg, lower_ms_next;
    logic [MS_W-1:0]      rise_ms_reg, rise_ms_next;
    logic [POS_W-1:0]     cur_pos_reg, cur_pos_next;
    logic [POS_W-1:0]     tgt_pos_reg, tgt_pos_next;
    logic [POS_W-1:0]     start_pos_reg, start_pos_next;
    dir_t                 dir_reg, dir_next;
    logic [TIME_W-1:0]    start_time_reg, start_time_next;
    logic [TOTAL_W-1:0]   span_reg, span_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 rep_reg, rep_next;
    logic                 out_valid_reg, out_valid_next;

    action_t              act_reg, act_next;
    logic [POS_W-1:0]     pct_reg, pct_next;
    logic                 radio_reg, radio_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [TIME_W-1:0]    elapsed_reg, elapsed_next;
    logic [MS10_W-1:0]    ms10_reg, ms10_next;
    logic [POS_W-1:0]     mul_a_reg, mul_a_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    out_item_t            out_data_reg, out_data_next;

    logic [TOTAL_W-1:0]   product;
    logic [TOTAL_W-1:0]   cmp_op;
    logic                 reached;
    logic                 moving;
    logic                 div_start;
    div_stat_t            div_stat;
    dir_t                 new_dir;
    logic [POS_W-1:0]     in_pct;

    assign product = TOTAL_W'(mul_a_reg) * TOTAL_W'(ms10_reg);
    assign cmp_op  = (act_reg == ACT_TICK) ? span_reg : total_reg;
    assign reached = (elapsed_reg[TIME_W-1:TOTAL_W] != '0)
                  || (elapsed_reg[TOTAL_W-1:0] >= cmp_op);
    assign moving  = (dir_reg != DIR_NONE);
    assign new_dir = (pct_reg > cur_pos_reg) ? DIR_DOWN : DIR_UP;

    always_comb
    begin
        case (action_t'(in_data.action))
            ACT_APP_MOVE:
                in_pct = (in_data.target_percent > PCT_W'(FULL_PCT)) ? FULL_PCT
                       : in_data.target_percent[POS_W-1:0];
            ACT_REMOTE_DOWN: in_pct = FULL_PCT;
            default:         in_pct = '0;
        endcase
    end

    ttpe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed_reg[TOTAL_W-1:0]),
        .divisor  (ms10_reg),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next      = state_reg;
        lower_ms_next   = lower_ms_reg;
        rise_ms_next    = rise_ms_reg;
        cur_pos_next    = cur_pos_reg;
        tgt_pos_next    = tgt_pos_reg;
        start_pos_next  = start_pos_reg;
        dir_next        = dir_reg;
        start_time_next = start_time_reg;
        span_next       = span_reg;
        cmd_next        = cmd_reg;
        rep_next        = rep_reg;
        out_valid_next  = out_valid_reg;
        act_next        = act_reg;
        pct_next        = pct_reg;
        radio_next      = radio_reg;
        now_next        = now_reg;
        elapsed_next    = elapsed_reg;
        ms10_next       = ms10_reg;
        mul_a_next      = mul_a_reg;
        total_next      = total_reg;
        out_data_next   = out_data_reg;
        div_start       = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LOWER_TIME: lower_ms_next = cfg_data[MS_W-1:0];
                REG_RISE_TIME:  rise_ms_next  = cfg_data[MS_W-1:0];
                default:        ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action_t'(in_data.action);
                    pct_next   = in_pct;
                    radio_next = (in_data.action inside {ACT_APP_MOVE, ACT_APP_STOP});
                    now_next   = in_data.now_us;
                    cmd_next   = CMD_NONE;
                    rep_next   = 1'b0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                elapsed_next = now_reg - start_time_reg;
                ms10_next    = times_ten((dir_reg == DIR_DOWN) ? lower_ms_reg : rise_ms_reg);
                mul_a_next   = abs_diff(tgt_pos_reg, start_pos_reg);
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                total_next = product;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_FINISH;
                case (act_reg)
                    ACT_TICK:
                    begin
                        if (moving && reached)
                        begin
                            cur_pos_next = tgt_pos_reg;
                            dir_next     = DIR_NONE;
                            rep_next     = 1'b1;
                            if (tgt_pos_reg != '0 && tgt_pos_reg != FULL_PCT)
                            begin
                                cmd_next = CMD_STOP;
                            end
                        end
                    end
                    ACT_APP_STOP, ACT_REMOTE_STOP,
                    ACT_APP_MOVE, ACT_REMOTE_UP, ACT_REMOTE_DOWN:
                    begin
                        if (act_reg inside {ACT_APP_STOP, ACT_REMOTE_STOP} && !moving)
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (moving && tgt_pos_reg == pct_reg
                                 && !(act_reg inside {ACT_APP_STOP, ACT_REMOTE_STOP}))
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (!moving)
                        begin
                            state_next = ST_APPLY;
                        end
                        else if (reached)
                        begin
                            cur_pos_next = tgt_pos_reg;
                            state_next   = ST_APPLY;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    cur_pos_next = (dir_reg == DIR_DOWN)
                                 ? (start_pos_reg + div_stat.quotient)
                                 : (start_pos_reg - div_stat.quotient);
                    state_next   = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                rep_next   = 1'b1;
                state_next = ST_FINISH;
                if (act_reg inside {ACT_APP_STOP, ACT_REMOTE_STOP})
                begin
                    cmd_next     = radio_reg ? CMD_STOP : CMD_NONE;
                    dir_next     = DIR_NONE;
                    tgt_pos_next = cur_pos_reg;
                end
                else
                begin
                    tgt_pos_next = pct_reg;
                    if (pct_reg == cur_pos_reg)
                    begin
                        cmd_next = (moving && radio_reg) ? CMD_STOP : CMD_NONE;
                        dir_next = DIR_NONE;
                    end
                    else
                    begin
                        dir_next        = new_dir;
                        start_pos_next  = cur_pos_reg;
                        start_time_next = now_reg;
                        if (radio_reg)
                        begin
                            cmd_next = (new_dir == DIR_DOWN) ? CMD_DOWN : CMD_UP;
                        end
                        mul_a_next = abs_diff(pct_reg, cur_pos_reg);
                        ms10_next  = times_ten((new_dir == DIR_DOWN) ? lower_ms_reg
                                                                     : rise_ms_reg);
                        state_next = ST_SPAN;
                    end
                end
            end
            ST_SPAN:
            begin
                span_next  = (product == '0) ? TOTAL_W'(1) : product;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.radio_cmd    = cmd_reg;
                    out_data_next.report_valid = rep_reg;
                    out_data_next.position     = cur_pos_reg;
                    out_data_next.moving       = moving;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lower_ms_reg   <= TRAVEL_RESET;
            rise_ms_reg    <= TRAVEL_RESET;
            cur_pos_reg    <= INIT_POS_RESET;
            tgt_pos_reg    <= INIT_POS_RESET;
            start_pos_reg  <= '0;
            dir_reg        <= DIR_NONE;
            start_time_reg <= '0;
            span_reg       <= '0;
            cmd_reg        <= CMD_NONE;
            rep_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lower_ms_reg   <= lower_ms_next;
            rise_ms_reg    <= rise_ms_next;
            cur_pos_reg    <= cur_pos_next;
            tgt_pos_reg    <= tgt_pos_next;
            start_pos_reg  <= start_pos_next;
            dir_reg        <= dir_next;
            start_time_reg <= start_time_next;
            span_reg       <= span_next;
            cmd_reg        <= cmd_next;
            rep_reg        <= rep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        pct_reg      <= pct_next;
        radio_reg    <= radio_next;
        now_reg      <= now_next;
        elapsed_reg  <= elapsed_next;
        ms10_reg     <= ms10_next;
        mul_a_reg    <= mul_a_next;
        total_reg    <= total_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `TTPE_ASSERT_ALWAYS(a_pos_in_range, cur_pos_reg <= FULL_PCT, "position estimate above full")
    `TTPE_ASSERT_IMP(a_cmd_reports,
        out_valid_reg && (out_data_reg.radio_cmd != CMD_NONE),
        out_data_reg.report_valid, "radio command without report")
    `TTPE_ASSERT_IMP(a_idle_cmd,
        out_valid_reg && !out_data_reg.moving,
        (out_data_reg.radio_cmd == CMD_NONE) || (out_data_reg.radio_cmd == CMD_STOP),
        "move command on a stopped result")
    `TTPE_ASSERT_IMP(a_div_active,
        state_reg == ST_DIV, div_stat.busy || div_stat.done,
        "sync wait with divider idle")

endmodule

`default_nettype wire
